/* rtl/tcon_pkg.sv */
// shared types and constants of the text console
// controller states and commands, datapath status, request opcodes and character codes
// no dependencies
package tcon_pkg;

  localparam logic [7:0] BLANK_CHAR   = 8'h20;
  localparam logic [7:0] TAB_CHAR     = 8'h09;
  localparam logic [7:0] NEWLINE_CHAR = 8'h0A;

  typedef enum logic [1:0] {
    OP_PRINT = 2'd0,
    OP_ERASE = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_PUT,
    ST_SCROLL,
    ST_CLEAR,
    ST_ERS_RD,
    ST_ERS_CHK,
    ST_FINISH
  } ctrl_state_e;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_ACCEPT,
    CMD_PUT,
    CMD_SCROLL,
    CMD_CLEAR,
    CMD_ERS_RD,
    CMD_ERS_CHK,
    CMD_FINISH
  } dp_cmd_e;

  typedef struct packed {
    op_e  req_op;
    logic put_scroll;
    logic tab_more;
    logic ers_search;
    logic ers_found;
    logic sw_col_last;
    logic sw_row_last;
    logic out_free;
  } dp_status_t;

endpackage

/* rtl/tcon_ctrl.sv */
// sequencing state machine of the text console
// issues one datapath command per cycle from the datapath status
// depends on tcon_pkg
module tcon_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  tcon_pkg::dp_status_t   status_i,
  output tcon_pkg::dp_cmd_e      cmd_o
);
  import tcon_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT: begin
        if (status_i.sw_col_last && status_i.sw_row_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          case (status_i.req_op)
            OP_PRINT: begin
              if (status_i.put_scroll)    state_d = ST_SCROLL;
              else if (status_i.tab_more) state_d = ST_PUT;
              else                        state_d = ST_FINISH;
            end
            OP_ERASE: state_d = status_i.ers_search ? ST_ERS_RD : ST_FINISH;
            OP_CLEAR: state_d = ST_CLEAR;
            OP_READ:  state_d = ST_FINISH;
            default:  state_d = ST_FINISH;
          endcase
        end
      end
      ST_PUT: begin
        if (status_i.put_scroll)    state_d = ST_SCROLL;
        else if (status_i.tab_more) state_d = ST_PUT;
        else                        state_d = ST_FINISH;
      end
      ST_SCROLL: begin
        if (status_i.sw_col_last) state_d = status_i.tab_more ? ST_PUT : ST_FINISH;
      end
      ST_CLEAR: begin
        if (status_i.sw_col_last && status_i.sw_row_last) state_d = ST_FINISH;
      end
      ST_ERS_RD:  state_d = ST_ERS_CHK;
      ST_ERS_CHK: begin
        state_d = status_i.ers_found ? ST_FINISH : ST_ERS_RD;
      end
      ST_FINISH: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_INIT;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = CMD_NONE;
    in_stall_o = 1'b1;
    case (state_q)
      ST_INIT:    cmd_o = CMD_CLEAR;
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o      = in_valid_i ? CMD_ACCEPT : CMD_NONE;
      end
      ST_PUT:     cmd_o = CMD_PUT;
      ST_SCROLL:  cmd_o = CMD_SCROLL;
      ST_CLEAR:   cmd_o = CMD_CLEAR;
      ST_ERS_RD:  cmd_o = CMD_ERS_RD;
      ST_ERS_CHK: cmd_o = CMD_ERS_CHK;
      ST_FINISH:  cmd_o = status_i.out_free ? CMD_FINISH : CMD_NONE;
      default:    cmd_o = CMD_NONE;
    endcase
  end

endmodule

/* rtl/tcon_dp.sv */
// datapath of the text console: screen memory, cursor, scroll offset,
// sweep counter and result register
// depends on tcon_pkg
module tcon_dp #(
  parameter int NUM_COLUMNS = 80,
  parameter int NUM_LINES   = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tcon_pkg::dp_cmd_e     cmd_i,
  output tcon_pkg::dp_status_t  status_o,
  input  logic [1:0]            op_i,
  input  logic [7:0]            ch_i,
  input  logic [4:0]            row_i,
  input  logic [6:0]            col_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [7:0]            cell_char_o,
  output logic [6:0]            cursor_col_o,
  output logic [4:0]            cursor_row_o
);
  import tcon_pkg::*;

  localparam int CW    = $clog2(NUM_COLUMNS);
  localparam int RW    = $clog2(NUM_LINES);
  localparam int AW    = RW + CW;
  localparam int Depth = 1 << AW;
  localparam logic [CW-1:0] ColLast  = CW'(NUM_COLUMNS - 1);
  localparam logic [RW-1:0] RowLast  = RW'(NUM_LINES - 1);
  localparam logic [7:0]    ColLimit = 8'(NUM_COLUMNS);
  localparam logic [6:0]    RowLimit = 7'(NUM_LINES);

  // logical line to physical memory row through the scroll offset
  function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] lrow,
                                              input logic [RW-1:0] top);
    logic [RW:0] sum;
    sum = {1'b0, lrow} + {1'b0, top};
    if (sum >= (RW+1)'(NUM_LINES)) sum = sum - (RW+1)'(NUM_LINES);
    return sum[RW-1:0];
  endfunction

  logic [7:0]    screen_mem_q [Depth];
  logic [7:0]    rdata_q;

  logic [CW-1:0] cur_col_q, cur_col_d;
  logic [RW-1:0] cur_row_q, cur_row_d;
  logic [RW-1:0] top_q, top_d;
  logic [CW-1:0] sw_col_q, sw_col_d;
  logic [RW-1:0] sw_row_q, sw_row_d;
  logic [1:0]    tab_left_q, tab_left_d;
  logic          rd_ok_q, rd_ok_d;
  logic          out_valid_q, out_valid_d;
  logic [7:0]    out_char_q, out_char_d;
  logic [6:0]    out_col_q, out_col_d;
  logic [4:0]    out_row_q, out_row_d;

  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wdata;

  op_e           in_op;
  logic [RW+4:0] in_row_ext;
  logic          in_range;
  logic [RW-1:0] prow, in_prow, last_prow;
  logic [CW-1:0] col_dec;
  logic [7:0]    put_char;
  logic          do_put, newline, scroll_evt, ers_found;
  logic [CW+6:0] col_ext;
  logic [RW+4:0] row_ext;
  logic          out_free;

  assign in_op      = op_e'(op_i);
  assign in_row_ext = {{RW{1'b0}}, row_i};
  assign in_range   = ({1'b0, col_i} < ColLimit) && ({2'b00, row_i} < RowLimit);
  assign prow       = phys_row(cur_row_q, top_q);
  assign in_prow    = phys_row(in_row_ext[RW-1:0], top_q);
  assign last_prow  = (top_q == '0) ? RowLast : top_q - 1'b1;
  assign col_dec    = cur_col_q - 1'b1;
  assign put_char   = (cmd_i == CMD_ACCEPT && ch_i != TAB_CHAR) ? ch_i : BLANK_CHAR;
  assign do_put     = (cmd_i == CMD_ACCEPT && in_op == OP_PRINT) || cmd_i == CMD_PUT;
  assign col_ext    = {7'd0, cur_col_q};
  assign row_ext    = {5'd0, cur_row_q};
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    cur_col_d   = cur_col_q;
    cur_row_d   = cur_row_q;
    top_d       = top_q;
    sw_col_d    = sw_col_q;
    sw_row_d    = sw_row_q;
    tab_left_d  = tab_left_q;
    rd_ok_d     = rd_ok_q;
    out_char_d  = out_char_q;
    out_col_d   = out_col_q;
    out_row_d   = out_row_q;
    we          = 1'b0;
    waddr       = '0;
    wdata       = BLANK_CHAR;
    re          = 1'b0;
    raddr       = '0;
    newline     = 1'b0;
    scroll_evt  = 1'b0;
    ers_found   = 1'b0;

    case (cmd_i)
      CMD_ACCEPT: begin
        rd_ok_d = in_range && in_op == OP_READ;
        case (in_op)
          OP_PRINT: tab_left_d = (ch_i == TAB_CHAR) ? 2'd3 : 2'd0;
          OP_ERASE: begin
            if (cur_col_q != '0) begin
              cur_col_d = col_dec;
              we        = 1'b1;
              waddr     = {prow, col_dec};
            end else if (cur_row_q != '0) begin
              // back up a line, search starts at its last column
              cur_row_d = cur_row_q - 1'b1;
              cur_col_d = ColLast;
            end
          end
          OP_CLEAR: begin
            cur_col_d = '0;
            cur_row_d = '0;
            top_d     = '0;
          end
          OP_READ: begin
            re    = in_range;
            raddr = {in_prow, col_i[CW-1:0]};
          end
          default: ;
        endcase
      end
      CMD_PUT: tab_left_d = tab_left_q - 1'b1;
      CMD_SCROLL: begin
        we       = 1'b1;
        waddr    = {last_prow, sw_col_q};
        sw_col_d = (sw_col_q == ColLast) ? '0 : sw_col_q + 1'b1;
      end
      CMD_CLEAR: begin
        we    = 1'b1;
        waddr = {sw_row_q, sw_col_q};
        if (sw_col_q == ColLast) begin
          sw_col_d = '0;
          sw_row_d = (sw_row_q == RowLast) ? '0 : sw_row_q + 1'b1;
        end else begin
          sw_col_d = sw_col_q + 1'b1;
        end
      end
      CMD_ERS_RD: begin
        re    = 1'b1;
        raddr = {prow, cur_col_q};
      end
      CMD_ERS_CHK: begin
        if (rdata_q == BLANK_CHAR && cur_col_q != '0) begin
          cur_col_d = col_dec;
        end else begin
          ers_found = 1'b1;
          we        = 1'b1;
          waddr     = {prow, cur_col_q};
        end
      end
      CMD_FINISH: begin
        out_char_d = rd_ok_q ? rdata_q : 8'd0;
        out_col_d  = col_ext[6:0];
        out_row_d  = row_ext[4:0];
      end
      default: ;
    endcase

    // one printed character: store and advance, wrap, scroll at the bottom
    if (do_put) begin
      if (put_char == NEWLINE_CHAR) begin
        newline = 1'b1;
      end else begin
        we    = 1'b1;
        waddr = {prow, cur_col_q};
        wdata = put_char;
        if (cur_col_q == ColLast) newline = 1'b1;
        else                      cur_col_d = cur_col_q + 1'b1;
      end
      if (newline) begin
        cur_col_d = '0;
        if (cur_row_q == RowLast) begin
          scroll_evt = 1'b1;
          top_d      = (top_q == RowLast) ? '0 : top_q + 1'b1;
        end else begin
          cur_row_d = cur_row_q + 1'b1;
        end
      end
    end

    if (cmd_i == CMD_FINISH)             out_valid_d = 1'b1;
    else if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    else                                  out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_col_q   <= '0;
      cur_row_q   <= '0;
      top_q       <= '0;
      sw_col_q    <= '0;
      sw_row_q    <= '0;
      tab_left_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cur_col_q   <= cur_col_d;
      cur_row_q   <= cur_row_d;
      top_q       <= top_d;
      sw_col_q    <= sw_col_d;
      sw_row_q    <= sw_row_d;
      tab_left_q  <= tab_left_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_ok_q    <= rd_ok_d;
    out_char_q <= out_char_d;
    out_col_q  <= out_col_d;
    out_row_q  <= out_row_d;
  end

  // screen memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (we) screen_mem_q[waddr] <= wdata;
    if (re) rdata_q <= screen_mem_q[raddr];
  end

  assign status_o.req_op      = in_op;
  assign status_o.put_scroll  = scroll_evt;
  assign status_o.tab_more    = tab_left_d != 2'd0;
  assign status_o.ers_search  = in_op == OP_ERASE && cur_col_q == '0 && cur_row_q != '0;
  assign status_o.ers_found   = ers_found;
  assign status_o.sw_col_last = sw_col_q == ColLast;
  assign status_o.sw_row_last = sw_row_q == RowLast;
  assign status_o.out_free    = out_free;

  assign out_valid_o  = out_valid_q;
  assign cell_char_o  = out_char_q;
  assign cursor_col_o = out_col_q;
  assign cursor_row_o = out_row_q;

  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_row_q <= RowLast)
    else $error("cursor line beyond screen");

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_col_q <= ColLast)
    else $error("cursor column beyond screen");

  a_top_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    top_q <= RowLast)
    else $error("scroll offset beyond screen");

  a_finish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i == CMD_FINISH |-> (!out_valid_q || !out_stall_i))
    else $error("result loaded over a held result");

  a_sweep_home: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i == CMD_ACCEPT |-> (sw_col_q == '0 && sw_row_q == '0))
    else $error("sweep counter not home at request");

endmodule

/* rtl/text_console_cursor_scroll.sv */
// text console with cursor, wrap, scroll and erase: top level
// joins the controller (tcon_ctrl) and the datapath (tcon_dp)
// depends on tcon_pkg
//
// usage:
//   request channel in_valid_i / in_stall_o carries op_i, ch_i, row_i, col_i;
//   a request is taken at a clock edge with in_valid_i high and in_stall_o low.
//   result channel out_valid_o / out_stall_i carries cell_char_o, cursor_col_o,
//   cursor_row_o; exactly one result per request, in request order.
// steps per request (one request at a time):
//   plain print, newline, erase inside a line, read: accepted, then the result posted
//   tab: four blank cells, one per cycle unless a scroll comes between
//   every scroll adds a pass that blanks the new bottom line; the
//   lines themselves are not moved, a row offset rotates instead
//   erase at column 0: the previous line is searched from its last column
//   back, each cell read through the memory read port and then checked
//   clear: every cell of the screen blanked, one cell written per cycle
// reset: a clearing pass writes spaces into the screen with in_stall_o high;
//   the cursor starts at line 0, column 0
// stall: the result register holds while out_stall_i is high; the next
//   request is still taken and worked on, and waits only to post its result
module text_console_cursor_scroll #(
  parameter int NUM_COLUMNS = 80,
  parameter int NUM_LINES   = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] op_i,
  input  logic [7:0] ch_i,
  input  logic [4:0] row_i,
  input  logic [6:0] col_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] cell_char_o,
  output logic [6:0] cursor_col_o,
  output logic [4:0] cursor_row_o
);
  import tcon_pkg::*;

  // command from the sequencer, status back from the datapath
  dp_cmd_e    cmd;
  dp_status_t status;

  tcon_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // screen memory is rows of a power-of-two column span, addressed by a
  // rotating row offset so that a scroll only blanks one line
  tcon_dp #(
    .NUM_COLUMNS (NUM_COLUMNS),
    .NUM_LINES   (NUM_LINES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .op_i         (op_i),
    .ch_i         (ch_i),
    .row_i        (row_i),
    .col_i        (col_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .cell_char_o  (cell_char_o),
    .cursor_col_o (cursor_col_o),
    .cursor_row_o (cursor_row_o)
  );

endmodule

/* test/text_console_cursor_scroll_checker.sv */
// checker for the text console: keeps its own screen and cursor, predicts one
// result per request and compares it with what comes back on the result channel
// depends on tcon_pkg
`timescale 1ns / 100ps
module text_console_cursor_scroll_checker #(
  parameter int NUM_COLUMNS = 80,
  parameter int NUM_LINES   = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [1:0] op_i,
  input  logic [7:0] ch_i,
  input  logic [4:0] row_i,
  input  logic [6:0] col_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [7:0] cell_char_i,
  input  logic [6:0] cursor_col_i,
  input  logic [4:0] cursor_row_i,
  output int         mismatch_count_o,
  output int         pending_o,
  output int         checked_o
);
  import tcon_pkg::*;

  typedef struct packed {
    logic [7:0] cell_char;
    logic [6:0] cursor_col;
    logic [4:0] cursor_row;
  } console_view_t;

  logic [7:0]    screen [NUM_LINES][NUM_COLUMNS];
  int unsigned   cursor_line;
  int unsigned   cursor_column;
  console_view_t views_due [$];
  int            mismatches;
  int            checked;

  function automatic void wipe_screen();
    for (int r = 0; r < NUM_LINES; r++)
      for (int c = 0; c < NUM_COLUMNS; c++)
        screen[r][c] = BLANK_CHAR;
    cursor_line   = 0;
    cursor_column = 0;
  endfunction

  // next line, scrolling everything up one line at the bottom
  function automatic void feed_line();
    cursor_column = 0;
    if (cursor_line + 1 >= NUM_LINES) begin
      for (int r = 0; r < NUM_LINES - 1; r++)
        for (int c = 0; c < NUM_COLUMNS; c++)
          screen[r][c] = screen[r + 1][c];
      for (int c = 0; c < NUM_COLUMNS; c++)
        screen[NUM_LINES - 1][c] = BLANK_CHAR;
      cursor_line = NUM_LINES - 1;
    end else begin
      cursor_line++;
    end
  endfunction

  function automatic void place_glyph(logic [7:0] glyph);
    screen[cursor_line][cursor_column] = glyph;
    if (cursor_column + 1 >= NUM_COLUMNS) feed_line();
    else cursor_column++;
  endfunction

  // at column 0 back up to the last non-space cell of the line above
  function automatic void erase_back();
    int unsigned pos;
    if (cursor_column > 0) begin
      cursor_column--;
      screen[cursor_line][cursor_column] = BLANK_CHAR;
      return;
    end
    if (cursor_line == 0) return;
    cursor_line--;
    pos = NUM_COLUMNS - 1;
    while (pos > 0 && screen[cursor_line][pos] == BLANK_CHAR) pos--;
    screen[cursor_line][pos] = BLANK_CHAR;
    cursor_column = pos;
  endfunction

  function automatic console_view_t predict_view(op_e op, logic [7:0] ch,
                                                 logic [4:0] row, logic [6:0] col);
    console_view_t v;
    v.cell_char = '0;
    case (op)
      OP_PRINT: begin
        if (ch == TAB_CHAR) repeat (4) place_glyph(BLANK_CHAR);
        else if (ch == NEWLINE_CHAR) feed_line();
        else place_glyph(ch);
      end
      OP_ERASE: erase_back();
      OP_CLEAR: wipe_screen();
      default: begin
        if (row < NUM_LINES && col < NUM_COLUMNS) v.cell_char = screen[row][col];
      end
    endcase
    v.cursor_col = cursor_column[6:0];
    v.cursor_row = cursor_line[4:0];
    return v;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch_channels
    console_view_t due;
    if (!rst_ni) begin
      wipe_screen();
      views_due.delete();
      mismatches = 0;
      checked    = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (views_due.size() == 0) begin
          $display("%0t: expected no result, got cell %02h col %0d row %0d",
                   $time, cell_char_i, cursor_col_i, cursor_row_i);
          mismatches++;
        end else begin
          due = views_due.pop_front();
          checked++;
          if (cell_char_i !== due.cell_char) begin
            $display("%0t: cell_char expected %02h, got %02h",
                     $time, due.cell_char, cell_char_i);
            mismatches++;
          end
          if (cursor_col_i !== due.cursor_col) begin
            $display("%0t: cursor_col expected %0d, got %0d",
                     $time, due.cursor_col, cursor_col_i);
            mismatches++;
          end
          if (cursor_row_i !== due.cursor_row) begin
            $display("%0t: cursor_row expected %0d, got %0d",
                     $time, due.cursor_row, cursor_row_i);
            mismatches++;
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        views_due.push_back(predict_view(op_e'(op_i), ch_i, row_i, col_i));
    end
    mismatch_count_o <= mismatches;
    pending_o        <= views_due.size();
    checked_o        <= checked;
  end

endmodule

/* test/text_console_cursor_scroll_tb.sv */
// top of the text console testbench: clock, reset, request stimulus and the
// random result stall; checking lives in text_console_cursor_scroll_checker
// depends on tcon_pkg, the console top level and the checker
`timescale 1ns / 100ps
module text_console_cursor_scroll_tb;
  import tcon_pkg::*;

  localparam int NUM_COLUMNS     = 80;
  localparam int NUM_LINES       = 32;
  localparam int RANDOM_REQUESTS = 1030;
  // longest non-clear request is an erase at column 0
  localparam int DRAIN_CYCLES    = 4 * NUM_COLUMNS;

  // what the random requests lean toward for a stretch
  typedef enum logic [1:0] {
    MODE_TYPING,
    MODE_SCROLL,
    MODE_ERASE,
    MODE_READBACK
  } stim_mode_e;

  logic       clk_i;
  logic       rst_ni    = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  op_e        req_op    = OP_READ;
  logic [7:0] req_ch    = '0;
  logic [4:0] req_row   = '0;
  logic [6:0] req_col   = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] cell_char;
  logic [6:0] cursor_col;
  logic [4:0] cursor_row;

  int mismatch_count;
  int pending;
  int checked;

  // stimulus bookkeeping
  int prints, erases, clears, reads;
  int quiet_requests = 0;
  logic draining = 1'b0;

  // result stall state
  int stall_hold = 0;
  bit stalling   = 1'b0;

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  text_console_cursor_scroll #(
    .NUM_COLUMNS(NUM_COLUMNS),
    .NUM_LINES  (NUM_LINES)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .op_i        (req_op),
    .ch_i        (req_ch),
    .row_i       (req_row),
    .col_i       (req_col),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .cell_char_o (cell_char),
    .cursor_col_o(cursor_col),
    .cursor_row_o(cursor_row)
  );

  text_console_cursor_scroll_checker #(
    .NUM_COLUMNS(NUM_COLUMNS),
    .NUM_LINES  (NUM_LINES)
  ) i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .op_i            (req_op),
    .ch_i            (req_ch),
    .row_i           (req_row),
    .col_i           (req_col),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .cell_char_i     (cell_char),
    .cursor_col_i    (cursor_col),
    .cursor_row_i    (cursor_row),
    .mismatch_count_o(mismatch_count),
    .pending_o       (pending),
    .checked_o       (checked)
  );

  // idle cycles before the next request: mostly none or a few, rarely long,
  // and now and then a run of back-to-back requests
  function automatic int request_gap();
    int r;
    if (quiet_requests > 0) begin
      quiet_requests--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      quiet_requests = $urandom_range(20, 60);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // valid stays up between back-to-back requests; it drops only for a gap
  task automatic issue_request(input op_e op, input logic [7:0] ch,
                               input logic [4:0] row, input logic [6:0] col);
    int gap;
    gap = request_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    req_op   <= op;
    req_ch   <= ch;
    req_row  <= row;
    req_col  <= col;
    do @(posedge clk_i); while (in_stall);
    case (op)
      OP_PRINT: prints++;
      OP_ERASE: erases++;
      OP_CLEAR: clears++;
      default:  reads++;
    endcase
  endtask

  // a byte to print: newlines at the given percentage, otherwise mostly
  // printable text with spaces, tabs and any byte at all mixed in
  function automatic logic [7:0] typed_char(int newline_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < newline_pct) return NEWLINE_CHAR;
    r = $urandom_range(0, 99);
    if (r < 6) return TAB_CHAR;
    if (r < 16) return 8'($urandom);
    if (r < 28) return BLANK_CHAR;
    return 8'($urandom_range(33, 126));
  endfunction

  task automatic random_request(input stim_mode_e mode);
    int r;
    int print_pct, erase_pct, newline_pct;
    case (mode)
      MODE_TYPING: begin print_pct = 78; erase_pct = 10; newline_pct = 6;  end
      MODE_SCROLL: begin print_pct = 85; erase_pct = 7;  newline_pct = 45; end
      MODE_ERASE:  begin print_pct = 35; erase_pct = 45; newline_pct = 15; end
      default:     begin print_pct = 40; erase_pct = 10; newline_pct = 10; end
    endcase
    // unused fields always carry junk so the block has to ignore them
    if ($urandom_range(0, 999) < 5) begin
      issue_request(OP_CLEAR, 8'($urandom), 5'($urandom), 7'($urandom));
    end else begin
      r = $urandom_range(0, 99);
      if (r < print_pct)
        issue_request(OP_PRINT, typed_char(newline_pct), 5'($urandom), 7'($urandom));
      else if (r < print_pct + erase_pct)
        issue_request(OP_ERASE, 8'($urandom), 5'($urandom), 7'($urandom));
      else
        // reads lean on the bottom lines, where scrolling moves text, and
        // sometimes land beyond the last column
        issue_request(OP_READ, 8'($urandom),
          5'(($urandom_range(0, 9) < 4) ? $urandom_range(NUM_LINES - 4, NUM_LINES - 1)
                                        : $urandom_range(0, NUM_LINES - 1)),
          7'(($urandom_range(0, 99) < 15) ? $urandom_range(NUM_COLUMNS, 127)
                                          : $urandom_range(0, NUM_COLUMNS - 1)));
    end
  endtask

  // result stall: short bursts mostly, a few long ones, and quiet stretches
  always @(posedge clk_i) begin : result_backpressure
    int r;
    if (!rst_ni || draining) begin
      stalling   = 1'b0;
      stall_hold = 0;
    end else if (stall_hold > 0) begin
      stall_hold--;
    end else if (stalling) begin
      stalling   = 1'b0;
      r          = $urandom_range(0, 99);
      stall_hold = (r < 10) ? $urandom_range(50, 200) : $urandom_range(0, 6);
    end else begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        stalling = 1'b1;
        r = $urandom_range(0, 99);
        if (r < 88) stall_hold = $urandom_range(0, 2);
        else if (r < 97) stall_hold = $urandom_range(3, 12);
        else stall_hold = $urandom_range(30, 80);
      end else begin
        stall_hold = $urandom_range(0, 3);
      end
    end
    out_stall <= stalling;
  end

  initial begin : stimulus
    stim_mode_e mode;
    int sent;
    int burst;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: the reset pass must have left spaces everywhere
    issue_request(OP_READ, 8'hA5, 5'd0, 7'd0);
    issue_request(OP_READ, 8'h5A, 5'(NUM_LINES - 1), 7'(NUM_COLUMNS - 1));
    // reads outside the screen give zero
    issue_request(OP_READ, 8'hFF, 5'd31, 7'd127);
    issue_request(OP_READ, 8'h00, 5'd0, 7'(NUM_COLUMNS));
    // erase at the home position does nothing
    issue_request(OP_ERASE, 8'hFF, 5'd31, 7'd127);
    // bytes stored as they are, control bytes other than tab and newline too
    issue_request(OP_PRINT, 8'h00, 5'd31, 7'd127);
    issue_request(OP_PRINT, 8'hFF, 5'd0, 7'd0);
    issue_request(OP_PRINT, 8'h0D, 5'd31, 7'd0);
    issue_request(OP_PRINT, 8'h41, 5'd0, 7'd127);
    // tab is four spaces
    issue_request(OP_PRINT, TAB_CHAR, 5'd5, 7'd5);
    issue_request(OP_PRINT, 8'h7E, 5'd0, 7'd0);
    // erase inside a line
    issue_request(OP_ERASE, 8'h00, 5'd0, 7'd0);
    issue_request(OP_READ, 8'h00, 5'd0, 7'd3);
    // newline, then erase at column 0 backs up onto the last character above
    issue_request(OP_PRINT, NEWLINE_CHAR, 5'd0, 7'd0);
    issue_request(OP_ERASE, 8'h00, 5'd0, 7'd0);
    issue_request(OP_READ, 8'h00, 5'd0, 7'd2);
    // erase at column 0 below an all-space line lands on column 0
    issue_request(OP_PRINT, NEWLINE_CHAR, 5'd0, 7'd0);
    issue_request(OP_PRINT, NEWLINE_CHAR, 5'd0, 7'd0);
    issue_request(OP_ERASE, 8'h00, 5'd0, 7'd0);
    // clear homes the cursor and blanks the screen
    issue_request(OP_CLEAR, 8'hFF, 5'd31, 7'd127);
    issue_request(OP_READ, 8'h00, 5'd0, 7'd0);

    // random: stretches that lean on typing, scrolling, erasing or reading back
    sent = 0;
    while (sent < RANDOM_REQUESTS) begin
      mode  = stim_mode_e'($urandom_range(0, 3));
      burst = $urandom_range(10, 60);
      repeat (burst) begin
        random_request(mode);
        sent++;
      end
    end
    in_valid <= 1'b0;
    draining <= 1'b1;

    // wait for every result, then a while longer for anything unexpected
    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("requests: %0d prints, %0d erases, %0d clears, %0d reads",
             prints, erases, clears, reads);
    $display("results compared against the predicted screen: %0d", checked);
    if (mismatch_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // generous bound: even if every request were a full clear the run ends well before
  initial begin : watchdog
    #80_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

/* filelist.f */
rtl/tcon_pkg.sv
rtl/tcon_ctrl.sv
rtl/tcon_dp.sv
rtl/text_console_cursor_scroll.sv
test/text_console_cursor_scroll_checker.sv
test/text_console_cursor_scroll_tb.sv
